FILE: rtl/pva_pkg.sv
// Shared constants, codes and types for the polyphonic voice allocator.
package pva_pkg;

	localparam int MAX_VOICES = 16;
	// the voice select word is 4 bits wide, so at most 16 voices can be addressed
	localparam int VID_W      = 4;
	localparam int VOICES     = (MAX_VOICES < (1 << VID_W)) ? MAX_VOICES : (1 << VID_W);
	localparam int VA_W       = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CNT_W      = 5;
	localparam int PITCH_W    = 32;
	localparam int AGE_W      = 16;
	localparam int REQ_W      = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [AGE_W-1:0] AGE_MAX = '1;

	localparam logic [REQ_W-1:0] REQ_START = 2'd0;
	localparam logic [REQ_W-1:0] REQ_STOP  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_END   = 2'd2;

	localparam logic CMD_START   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_VOICES  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRIG  = 1'b1;

	typedef struct packed {
		logic signed [PITCH_W-1:0] pitch;
		logic [AGE_W-1:0]          age;
		logic                      active;
	} voice_t;

	typedef struct packed {
		logic                      age_we;
		logic [VA_W-1:0]           age_addr;
		logic [AGE_W-1:0]          age_val;
		logic                      set_we;
		logic [VA_W-1:0]           set_addr;
		logic signed [PITCH_W-1:0] set_pitch;
		logic                      clr_we;
		logic [VA_W-1:0]           clr_addr;
	} vf_wr_t;

	typedef struct packed {
		logic             pitch_hit;
		logic [AGE_W-1:0] aged;
		logic             older;
	} scan_res_t;

endpackage

FILE: rtl/pva_voice_file.sv
// Per-voice state registers: pitch, age and active bit, one read port.
module pva_voice_file
	import pva_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic [VA_W-1:0] rd_addr,
	output voice_t          rd_voice,
	input  vf_wr_t          wr
);

	voice_t voice_q [VOICES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOICES; i++) begin
				voice_q[i] <= '0;
			end
		end else begin
			if (wr.age_we) begin
				voice_q[wr.age_addr].age <= wr.age_val;
			end
			if (wr.set_we) begin
				voice_q[wr.set_addr].pitch  <= wr.set_pitch;
				voice_q[wr.set_addr].age    <= '0;
				voice_q[wr.set_addr].active <= 1'b1;
			end
			if (wr.clr_we) begin
				voice_q[wr.clr_addr].active <= 1'b0;
			end
		end
	end

	assign rd_voice = voice_q[rd_addr];

endmodule

FILE: rtl/pva_scan_unit.sv
// Shared per-voice compare unit: pitch match, saturating age step, age compare.
module pva_scan_unit
	import pva_pkg::*;
(
	input  voice_t                    voice,
	input  logic signed [PITCH_W-1:0] req_pitch,
	input  logic [AGE_W-1:0]          best_age,
	output scan_res_t                 res
);

	always_comb begin
		res.pitch_hit = (voice.pitch == req_pitch);
		if (voice.active && (voice.age != AGE_MAX)) begin
			res.aged = voice.age + AGE_W'(1);
		end else begin
			res.aged = voice.age;
		end
		res.older = (res.aged > best_age);
	end

endmodule

FILE: rtl/polyphonic_voice_allocator_unit.sv
// Polyphonic voice allocator top level: sequencer, request and output registers.
// Start: voices in use pass one per cycle through the shared scan unit, then writeback
//   loads the start word once the output is free. One request at a time.
// Stop: voices in use are scanned, then indices walked one per cycle to emit releases,
// pausing on a match while the output stalls. Ended and idle-start requests end in idle.
// Reset (arst_n low, async) clears all voice state, registers and the output word.
module polyphonic_voice_allocator_unit
	import pva_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	// request channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [REQ_W-1:0]          req_type,
	input  logic signed [PITCH_W-1:0] note_pitch,
	input  logic [VID_W-1:0]          ended_voice,
	// command channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      command,
	output logic [VID_W-1:0]          voice_sel,
	output logic                      last,
	// configuration writes
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_WRBK = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q;

	// config registers
	logic [CNT_W-1:0] voices_q;
	logic             retrig_q;
	logic [CNT_W-1:0] live_n;

	// request registers
	logic [REQ_W-1:0]          type_q;
	logic signed [PITCH_W-1:0] pitch_q;

	// scan bookkeeping
	logic [VID_W-1:0]       idx_q;
	logic [VA_W-1:0]        ix;
	logic                   found_q;
	logic [VA_W-1:0]        match_q;
	logic                   free_found_q;
	logic [VA_W-1:0]        free_q;
	logic [VA_W-1:0]        oldest_q;
	logic [AGE_W-1:0]       best_q;
	logic [VOICES-1:0]      mask_q;
	logic [VOICES-1:0]      ix_bit;
	logic [VOICES-1:0]      mask_scan;
	logic [VOICES-1:0]      mask_left;
	logic                   scan_done;
	logic [VA_W-1:0]        chosen;

	// output word
	logic             out_valid_q;
	logic             cmd_q;
	logic [VID_W-1:0] vidx_q;
	logic             last_q;
	logic             out_free;
	logic             word_load;

	logic      in_acc;
	logic      ended_ok;
	voice_t    rd_voice;
	scan_res_t sr;
	vf_wr_t    wr;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// voices beyond the storage depth never take part
	assign live_n = (voices_q > CNT_W'(VOICES)) ? CNT_W'(VOICES) : voices_q;

	assign ix        = idx_q[VA_W-1:0];
	assign ix_bit    = VOICES'(1) << ix;
	assign scan_done = ({1'b0, idx_q} == (live_n - CNT_W'(1)));
	assign ended_ok  = (32'(ended_voice) < VOICES);

	// stop: mask including the voice scanned this cycle
	assign mask_scan = (rd_voice.active && sr.pitch_hit) ? (mask_q | ix_bit) : mask_q;
	// emit: matches still pending after this release
	assign mask_left = mask_q & ~ix_bit;

	// retrigger match wins, then first free voice, then the oldest
	assign chosen = found_q ? match_q : (free_found_q ? free_q : oldest_q);

	// a new output word is loaded this cycle
	assign word_load = out_free
	                   && ((state_q == ST_WRBK) || ((state_q == ST_EMIT) && mask_q[ix]));

	pva_voice_file u_vf (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (ix),
		.rd_voice (rd_voice),
		.wr       (wr)
	);

	pva_scan_unit u_scan (
		.voice     (rd_voice),
		.req_pitch (pitch_q),
		.best_age  (best_q),
		.res       (sr)
	);

	always_comb begin
		wr.age_we    = (state_q == ST_SCAN) && (type_q == REQ_START) && rd_voice.active;
		wr.age_addr  = ix;
		wr.age_val   = sr.aged;
		wr.set_we    = (state_q == ST_WRBK) && out_free;
		wr.set_addr  = chosen;
		wr.set_pitch = pitch_q;
		wr.clr_we    = in_acc && (req_type == REQ_END) && ended_ok;
		wr.clr_addr  = VA_W'(ended_voice);
	end

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voices_q <= '0;
			retrig_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VOICES: voices_q <= cfg_data;
				CFG_RETRIG: retrig_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			type_q       <= REQ_START;
			pitch_q      <= '0;
			idx_q        <= '0;
			found_q      <= 1'b0;
			match_q      <= '0;
			free_found_q <= 1'b0;
			free_q       <= '0;
			oldest_q     <= '0;
			best_q       <= '0;
			mask_q       <= '0;
			out_valid_q  <= 1'b0;
			cmd_q        <= CMD_START;
			vidx_q       <= '0;
			last_q       <= 1'b0;
		end else begin
			// word held while stalled, dropped once taken
			if (word_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						type_q       <= req_type;
						pitch_q      <= note_pitch;
						idx_q        <= '0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						mask_q       <= '0;
						// start and stop walk the voices; nothing to walk if none in use
						if (((req_type == REQ_START) || (req_type == REQ_STOP))
						    && (live_n != '0)) begin
							state_q <= ST_SCAN;
						end
					end
				end

				ST_SCAN: begin
					if (type_q == REQ_START) begin
						if (retrig_q && sr.pitch_hit) begin
							found_q <= 1'b1;
							match_q <= ix;
						end
						if (rd_voice.active) begin
							if ((idx_q == '0) || sr.older) begin
								oldest_q <= ix;
								best_q   <= sr.aged;
							end
						end else begin
							// voice 0 seeds the oldest search even when idle
							if (idx_q == '0) begin
								oldest_q <= '0;
								best_q   <= rd_voice.age;
							end
							if (!free_found_q) begin
								free_found_q <= 1'b1;
								free_q       <= ix;
							end
						end
					end else begin
						mask_q <= mask_scan;
					end

					if (scan_done) begin
						idx_q <= '0;
						if (type_q == REQ_START) begin
							state_q <= ST_WRBK;
						end else if (mask_scan != '0) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						idx_q <= idx_q + VID_W'(1);
					end
				end

				ST_WRBK: begin
					if (out_free) begin
						cmd_q   <= CMD_START;
						vidx_q  <= VID_W'(chosen);
						last_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end

				ST_EMIT: begin
					if (mask_q[ix]) begin
						if (out_free) begin
							cmd_q  <= CMD_RELEASE;
							vidx_q <= idx_q;
							last_q <= (mask_left == '0);
							mask_q <= mask_left;
							idx_q  <= idx_q + VID_W'(1);
							if (mask_left == '0) begin
								state_q <= ST_IDLE;
							end
						end
					end else begin
						idx_q <= idx_q + VID_W'(1);
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign command   = cmd_q;
	assign voice_sel = vidx_q;
	assign last      = last_q;

endmodule

FILE: sim/tb_polyphonic_voice_allocator_unit.sv
// Self-checking testbench for the polyphonic voice allocator: directed table, random traffic.
`timescale 1ns / 1ps

module tb_polyphonic_voice_allocator_unit;
	import pva_pkg::*;

	// Request code the block must ignore.
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	// Longest quiet stretch: the receiver hold-off (HOLD_CYCLES) plus one full stop walk
	// (scan and emit over all voices) and long random stall runs, taken several times over.
	localparam int WATCHDOG_LIMIT = 4000;
	// Stop with no match emits nothing but still scans every voice in use; pad that.
	localparam int SETTLE_CYCLES  = 48;
	localparam int HOLD_CYCLES    = 300;
	localparam int N_DIR          = 25;

	typedef struct packed {
		logic             cmd;
		logic [VID_W-1:0] idx;
		logic             lst;
	} cmd_word_t;

	typedef struct packed {
		logic               is_cfg;
		logic [REQ_W-1:0]   req;
		logic [PITCH_W-1:0] pitch;
		logic [VID_W-1:0]   ended;
		logic [CNT_W-1:0]   voices;
		logic               retrig;
		logic               typed;     // expectation given in the row itself
		logic               has_word;  // typed row expects one start/release word
		cmd_word_t          word;
	} stim_row_t;

	// ---------------------------------------------------------------- DUT ports
	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic [REQ_W-1:0]      req_type    = REQ_START;
	logic signed [PITCH_W-1:0] note_pitch = '0;
	logic [VID_W-1:0]      ended_voice = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic                  command;
	logic [VID_W-1:0]      voice_sel;
	logic                  last;
	logic                  cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = CFG_VOICES;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;

	polyphonic_voice_allocator_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.note_pitch  (note_pitch),
		.ended_voice (ended_voice),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.command     (command),
		.voice_sel   (voice_sel),
		.last        (last),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------- voice predictor
	logic [PITCH_W-1:0] vp_pitch  [VOICES];
	logic [AGE_W-1:0]   vp_age    [VOICES];
	logic               vp_active [VOICES];
	logic [CNT_W-1:0]   vp_voices = '0;
	logic               vp_retrig = 1'b0;

	cmd_word_t alloc_words [VOICES];  // words caused by the latest request
	int        alloc_cnt;
	cmd_word_t cmd_due [$];           // start/release words still owed by the block

	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int fail_cnt     = 0;

	initial begin
		for (int v = 0; v < VOICES; v++) begin
			vp_pitch[v]  = '0;
			vp_age[v]    = '0;
			vp_active[v] = 1'b0;
		end
	end

	// Advance the voice table by one request and collect the words it causes.
	task automatic allocate_voice(input logic [REQ_W-1:0] rq, input logic [PITCH_W-1:0] p,
			input logic [VID_W-1:0] ev);
		int n, i, match, free_idx, oldest, chosen;
		bit found, got_free;
		n = (vp_voices > VOICES) ? VOICES : int'(vp_voices);
		alloc_cnt = 0;
		found = 1'b0;
		got_free = 1'b0;
		match = 0;
		free_idx = 0;
		oldest = 0;
		case (rq)
		REQ_START: begin
			if (n > 0) begin
				for (i = 0; i < n; i++) begin
					if (vp_retrig && vp_pitch[i] == p) begin
						found = 1'b1;
						match = i;
					end
					if (vp_active[i]) begin
						if (vp_age[i] != AGE_MAX) vp_age[i] = vp_age[i] + 1'b1;
						if (vp_age[i] > vp_age[oldest]) oldest = i;
					end else if (!got_free) begin
						got_free = 1'b1;
						free_idx = i;
					end
				end
				chosen = found ? match : (got_free ? free_idx : oldest);
				vp_pitch[chosen]  = p;
				vp_age[chosen]    = '0;
				vp_active[chosen] = 1'b1;
				alloc_words[0] = {CMD_START, VID_W'(chosen), 1'b1};
				alloc_cnt = 1;
			end
		end
		REQ_STOP: begin
			for (i = 0; i < n; i++) begin
				if (vp_active[i] && vp_pitch[i] == p) begin
					alloc_words[alloc_cnt] = {CMD_RELEASE, VID_W'(i), 1'b0};
					alloc_cnt++;
				end
			end
			if (alloc_cnt > 0) alloc_words[alloc_cnt-1].lst = 1'b1;
		end
		REQ_END: begin
			if (ev < MAX_VOICES) vp_active[ev] = 1'b0;
		end
		default: ;
		endcase
	endtask

	// -------------------------------------------------------------- row builders
	function automatic stim_row_t req_row(input logic [REQ_W-1:0] rq,
			input logic [PITCH_W-1:0] p, input logic [VID_W-1:0] ev);
		stim_row_t r;
		r = '0;
		r.req = rq;
		r.pitch = p;
		r.ended = ev;
		return r;
	endfunction

	// Row whose outcome is obvious: nothing, or a single word with last set.
	function automatic stim_row_t typed_row(input logic [REQ_W-1:0] rq,
			input logic [PITCH_W-1:0] p, input logic [VID_W-1:0] ev, input logic hw,
			input logic cmd, input logic [VID_W-1:0] idx);
		stim_row_t r;
		r = req_row(rq, p, ev);
		r.typed = 1'b1;
		r.has_word = hw;
		r.word = {cmd, idx, 1'b1};
		return r;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CNT_W-1:0] nv, input logic rt);
		stim_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.voices = nv;
		r.retrig = rt;
		return r;
	endfunction

	// ------------------------------------------------------------ request side
	// Offer one request word, wait for the handshake, then book its outcome.
	// Returns at the accepting edge with valid still high.
	task automatic send_row(input stim_row_t r);
		int k;
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= r.req;
		note_pitch  <= r.pitch;
		ended_voice <= r.ended;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		allocate_voice(r.req, r.pitch, r.ended);
		if (r.typed) begin
			if (r.has_word) cmd_due.push_back(r.word);
		end else begin
			for (k = 0; k < alloc_cnt; k++) cmd_due.push_back(alloc_words[k]);
		end
	endtask

	// Stop offering, let every owed word come out, then give a silent walk time to end.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (cmd_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Both registers back to back; cfg_we stays high across both writes.
	task automatic set_config(input logic [CNT_W-1:0] nv, input logic rt);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_VOICES;
		cfg_data  <= CFG_DATA_W'(nv);
		@(posedge clk);
		vp_voices = nv;
		cfg_index <= CFG_RETRIG;
		cfg_data  <= CFG_DATA_W'(rt);
		@(posedge clk);
		vp_retrig = rt;
		cfg_we <= 1'b0;
	endtask

	// Random note traffic. Pitches mostly come from a small pool so starts collide
	// and stops hit; stops and ends are usually aimed at voices that are sounding.
	task automatic run_traffic(input int n_items);
		stim_row_t r;
		logic [PITCH_W-1:0] pool [6];
		int k, sent, pick, v;
		for (k = 0; k < 6; k++) pool[k] = $urandom;
		k = 0;
		sent = 0;
		while (k < n_items) begin
			r = '0;
			r.ended = VID_W'($urandom_range(VOICES-1));
			r.pitch = ($urandom_range(99) < 85) ? pool[$urandom_range(5)] : $urandom;
			pick = $urandom_range(99);
			v = $urandom_range(VOICES-1);
			if (!vp_active[v]) v = $urandom_range(VOICES-1);
			if (pick < 45) begin
				r.req = REQ_START;
			end else if (pick < 75) begin
				r.req = REQ_STOP;
				if (pick < 65 && vp_active[v]) r.pitch = vp_pitch[v];
			end else if (pick < 92) begin
				r.req = REQ_END;
				if (pick < 86) r.ended = VID_W'(v);
			end else begin
				r.req = REQ_UNUSED;
			end
			send_row(r);
			sent++;
			if (r.req != REQ_UNUSED) k++;
			// sender pause: let the command side run dry now and then
			if (sent % 40 == 39) wait_idle();
		end
	endtask

	// ------------------------------------------------------------ command side
	task automatic check_word();
		cmd_word_t seen, due;
		seen = {command, voice_sel, last};
		if (cmd_due.size() == 0) begin
			fail_cnt++;
			if (fail_cnt <= 10)
				$display("unexpected word: cmd %0d voice %0d last %0d",
					seen.cmd, seen.idx, seen.lst);
		end else begin
			due = cmd_due.pop_front();
			if (seen !== due) begin
				fail_cnt++;
				if (fail_cnt <= 10)
					$display("word mismatch: exp cmd/voice/last %0d/%0d/%0d, got %0d/%0d/%0d",
						due.cmd, due.idx, due.lst, seen.cmd, seen.idx, seen.lst);
			end
		end
	endtask

	// Receiver: check at each accepting edge, then pick the stall for the next cycle.
	// A hold-off request from the stimulus keeps stall high until the HOLD_CYCLES countdown runs out.
	int hold_asked  = 0;
	int hold_served = 0;
	int hold_left   = 0;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) check_word();
		if (hold_asked != hold_served) begin
			hold_served <= hold_asked;
			hold_left   <= HOLD_CYCLES;
			out_stall   <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	// Watchdog: cycles with no handshake on either channel.
	int quiet = 0;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// ---------------------------------------------------------------- stimulus
	initial begin : stimulus
		stim_row_t dir_rows [N_DIR];
		int i;

		// Directed table. Typed rows carry their outcome; the rest use the predictor.
		// After reset no voices take part, so a start is swallowed.
		dir_rows[0]  = typed_row(REQ_START, 32'h7FFF_FFFF, 4'd0, 1'b0, CMD_START, 4'd0);
		dir_rows[1]  = cfg_row(5'd16, 1'b0);
		// free voices are handed out lowest first
		dir_rows[2]  = typed_row(REQ_START, 32'h8000_0000, 4'd0, 1'b1, CMD_START, 4'd0);
		dir_rows[3]  = typed_row(REQ_START, 32'h7FFF_FFFF, 4'd0, 1'b1, CMD_START, 4'd1);
		dir_rows[4]  = typed_row(REQ_START, 32'h0000_0000, 4'd0, 1'b1, CMD_START, 4'd2);
		dir_rows[5]  = typed_row(REQ_STOP, 32'h8000_0000, 4'd0, 1'b1, CMD_RELEASE, 4'd0);
		// released voice still sounds until it ends, so it is released again
		dir_rows[6]  = typed_row(REQ_STOP, 32'h8000_0000, 4'd0, 1'b1, CMD_RELEASE, 4'd0);
		// stop with no sounding match
		dir_rows[7]  = typed_row(REQ_STOP, 32'h1234_5678, 4'd0, 1'b0, CMD_START, 4'd0);
		// unknown request type
		dir_rows[8]  = typed_row(REQ_UNUSED, 32'hFFFF_FFFF, 4'd15, 1'b0, CMD_START, 4'd0);
		dir_rows[9]  = typed_row(REQ_END, 32'hFFFF_FFFF, 4'd15, 1'b0, CMD_START, 4'd0);
		dir_rows[10] = typed_row(REQ_END, 32'h0000_0000, 4'd0, 1'b0, CMD_START, 4'd0);
		dir_rows[11] = typed_row(REQ_STOP, 32'h8000_0000, 4'd0, 1'b0, CMD_START, 4'd0);
		dir_rows[12] = cfg_row(5'd16, 1'b1);
		// retrigger onto the sounding voice that holds the pitch
		dir_rows[13] = typed_row(REQ_START, 32'h7FFF_FFFF, 4'd0, 1'b1, CMD_START, 4'd1);
		// retrigger also hits silent voices still storing the pitch (last one wins)
		dir_rows[14] = req_row(REQ_START, 32'h0000_0000, 4'd0);
		dir_rows[15] = cfg_row(5'd1, 1'b0);
		dir_rows[16] = req_row(REQ_START, 32'h0000_FFFF, 4'd0);
		// single voice in use: steal it
		dir_rows[17] = req_row(REQ_START, 32'hFFFF_0000, 4'd0);
		// ended index outside the voices in use still silences that voice
		dir_rows[18] = typed_row(REQ_END, 32'h0000_0000, 4'd2, 1'b0, CMD_START, 4'd0);
		// voice count beyond the table is clipped to 16
		dir_rows[19] = cfg_row(5'd31, 1'b1);
		dir_rows[20] = req_row(REQ_STOP, 32'h0000_0000, 4'd0);
		dir_rows[21] = typed_row(REQ_STOP, 32'h7FFF_FFFF, 4'd0, 1'b1, CMD_RELEASE, 4'd1);
		dir_rows[22] = req_row(REQ_START, 32'h5555_5555, 4'd5);
		dir_rows[23] = req_row(REQ_START, 32'hAAAA_AAAA, 4'd10);
		dir_rows[24] = req_row(REQ_STOP, 32'h5555_5555, 4'd10);

		snd_idle_pct = 37;
		rcv_idle_pct = 63;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_DIR; i++) begin
			if (dir_rows[i].is_cfg) begin
				wait_idle();
				set_config(dir_rows[i].voices, dir_rows[i].retrig);
			end else begin
				send_row(dir_rows[i]);
			end
		end

		// Random traffic over several settings and idling patterns.
		wait_idle();
		set_config(5'd16, 1'b0);
		run_traffic(25);
		wait_idle();
		set_config(5'd5, 1'b1);
		run_traffic(25);

		wait_idle();
		snd_idle_pct = 63;
		rcv_idle_pct = 37;
		set_config(5'd31, 1'b1);
		run_traffic(25);
		wait_idle();
		set_config(5'd1, 1'b0);
		run_traffic(15);

		wait_idle();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		set_config(5'd16, 1'b1);
		// command side blocks for a long stretch while requests keep coming
		hold_asked++;
		run_traffic(30);
		wait_idle();
		set_config(5'd0, 1'b0);
		run_traffic(10);
		wait_idle();
		set_config(5'd9, 1'b0);
		run_traffic(20);

		wait_idle();
		if (fail_cnt == 0 && cmd_due.size() == 0) begin
			$display("status: pass");
		end else begin
			if (cmd_due.size() != 0) $display("words never seen: %0d", cmd_due.size());
			$display("status: fail");
		end
		$finish;
	end

endmodule
